/* rtl/dkat_pkg.sv */
package dkat_pkg;

	localparam int MAX_ENTRIES_DEF = 64;

	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int YEAR_W    = 12;
	localparam int HOURS_W   = 8;
	localparam int KEY_W     = 21;
	localparam int TOTAL_W   = 16;
	localparam int ECOUNT_W  = 7;
	localparam int STATUS_W  = 3;

	localparam int MONTH_MULT = 31;
	localparam int MONTHS     = 12;
	localparam int YEAR_MULT  = MONTH_MULT * MONTHS;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_MERGED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_APPEND  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_HIT     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_MISS    = 3'd4;

	typedef struct packed {
		logic               just;
		logic [TOTAL_W-1:0] hours;
		logic [KEY_W-1:0]   key;
	} rec_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	function automatic logic [KEY_W-1:0] date_key(
		input logic [DAY_W-1:0]   d,
		input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0]  y
	);
		logic [KEY_W-1:0] mk;
		logic [KEY_W-1:0] yk;
		mk = KEY_W'(m) * KEY_W'(MONTH_MULT);
		yk = KEY_W'(y) * KEY_W'(YEAR_MULT);
		return KEY_W'(d) + mk + yk;
	endfunction

endpackage

/* rtl/dkat_ram.sv */
module dkat_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/date_keyed_accumulate_table.sv */
// The result is valid once the key scan ends: the scan stops early on a hit,
// and an empty table skips the scan and goes straight to the result.
// One request at a time: the next request is taken only after the result is issued,
// held back by the key scan through the single read port of the
// record memory, one stored key per cycle, plus any result stall.
// Reset: arst_n clears the record count and control at once; memory contents
// are left as they are and only entries below the count are ever read.
module date_keyed_accumulate_table #(
	parameter int MAX_ENTRIES = dkat_pkg::MAX_ENTRIES_DEF,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // day, month, year, hours, justified, zero pad
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // hours_total, justified_out, entry_count
	output logic [2:0]  m_tuser    // status
);

	localparam int RW = $bits(dkat_pkg::rec_t);

	dkat_pkg::state_t state_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_idx_q;
	logic [CW-1:0] cmp_idx_s1;
	logic          rd_vld_s1;

	logic                          req_q;
	logic [dkat_pkg::KEY_W-1:0]    key_q;
	logic [dkat_pkg::HOURS_W-1:0]  hours_q;
	logic                          just_q;
	logic                          hit_q;
	logic [AW-1:0]                 at_q;
	dkat_pkg::rec_t                hit_rec_q;

	logic                              m_tvalid_q;
	logic [dkat_pkg::STATUS_W-1:0]     out_status_q;
	logic [dkat_pkg::TOTAL_W-1:0]      out_total_q;
	logic                              out_just_q;
	logic [dkat_pkg::ECOUNT_W-1:0]     out_count_q;

	logic           rd_en;
	logic [RW-1:0]  rd_raw;
	dkat_pkg::rec_t rd_rec;
	logic           key_match;
	logic           scan_last;
	logic           scan_done;

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	dkat_pkg::rec_t wr_rec;

	logic                          out_free;
	logic [dkat_pkg::TOTAL_W:0]    sum_full;
	logic [dkat_pkg::TOTAL_W-1:0]  sum_sat;
	logic                          table_full;
	logic [dkat_pkg::STATUS_W-1:0] fin_status;
	logic [dkat_pkg::TOTAL_W-1:0]  fin_total;
	logic                          fin_just;
	logic [CW-1:0]                 fin_count;

	assign s_tready = (state_q == dkat_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_count_q, out_just_q, out_total_q};

	assign rd_rec    = dkat_pkg::rec_t'(rd_raw);
	assign key_match = rd_vld_s1 && (rd_rec.key == key_q);
	assign scan_last = rd_vld_s1 && (CW'(cmp_idx_s1 + 1'b1) == count_q);
	assign scan_done = key_match || scan_last;
	assign rd_en     = (state_q == dkat_pkg::ST_SCAN) && !scan_done && (issue_idx_q < count_q);

	assign out_free   = !m_tvalid_q || m_tready;
	assign table_full = (count_q == CW'(MAX_ENTRIES));
	assign sum_full   = {1'b0, hit_rec_q.hours} + (dkat_pkg::TOTAL_W + 1)'(hours_q);
	assign sum_sat    = sum_full[dkat_pkg::TOTAL_W] ? dkat_pkg::TOTAL_MAX
	                                                : sum_full[dkat_pkg::TOTAL_W-1:0];

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = at_q;
		wr_rec     = hit_rec_q;
		fin_count  = count_q;
		fin_status = dkat_pkg::STAT_MISS;
		fin_total  = '0;
		fin_just   = 1'b0;
		priority if (req_q == dkat_pkg::REQ_SEARCH) begin
			if (hit_q) begin
				fin_status = dkat_pkg::STAT_HIT;
				fin_total  = hit_rec_q.hours;
				fin_just   = hit_rec_q.just;
			end
		end else if (hit_q) begin
			fin_status   = dkat_pkg::STAT_MERGED;
			wr_rec.hours = sum_sat;
			wr_rec.just  = hit_rec_q.just | just_q;
			fin_total    = sum_sat;
			fin_just     = hit_rec_q.just | just_q;
			wr_en        = 1'b1;
		end else if (table_full) begin
			fin_status = dkat_pkg::STAT_FULL;
		end else begin
			fin_status   = dkat_pkg::STAT_APPEND;
			wr_addr      = count_q[AW-1:0];
			wr_rec.key   = key_q;
			wr_rec.hours = dkat_pkg::TOTAL_W'(hours_q);
			wr_rec.just  = just_q;
			fin_total    = dkat_pkg::TOTAL_W'(hours_q);
			fin_just     = just_q;
			fin_count    = CW'(count_q + 1'b1);
			wr_en        = 1'b1;
		end
	end

	dkat_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en && (state_q == dkat_pkg::ST_FINISH) && out_free),
		.waddr(wr_addr),
		.wdata(wr_rec),
		.re   (rd_en),
		.raddr(issue_idx_q[AW-1:0]),
		.rdata(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dkat_pkg::ST_IDLE;
			count_q     <= '0;
			issue_idx_q <= '0;
			rd_vld_s1   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (state_q == dkat_pkg::ST_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				dkat_pkg::ST_IDLE: begin
					issue_idx_q <= '0;
					if (s_tvalid) begin
						state_q <= (count_q == '0) ? dkat_pkg::ST_FINISH : dkat_pkg::ST_SCAN;
					end
				end
				dkat_pkg::ST_SCAN: begin
					if (rd_en) begin
						issue_idx_q <= CW'(issue_idx_q + 1'b1);
					end
					if (scan_done) begin
						state_q <= dkat_pkg::ST_FINISH;
					end
				end
				dkat_pkg::ST_FINISH: begin
					if (out_free) begin
						count_q <= fin_count;
						state_q <= dkat_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= dkat_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= issue_idx_q;
		if (state_q == dkat_pkg::ST_IDLE && s_tvalid) begin
			req_q   <= s_tuser;
			key_q   <= dkat_pkg::date_key(s_tdata[4:0], s_tdata[8:5], s_tdata[20:9]);
			hours_q <= s_tdata[28:21];
			just_q  <= s_tdata[29];
			hit_q   <= 1'b0;
		end
		if (state_q == dkat_pkg::ST_SCAN && scan_done) begin
			hit_q     <= key_match;
			at_q      <= cmp_idx_s1[AW-1:0];
			hit_rec_q <= rd_rec;
		end
		if (state_q == dkat_pkg::ST_FINISH && out_free) begin
			out_status_q <= fin_status;
			out_total_q  <= fin_total;
			out_just_q   <= fin_just;
			out_count_q  <= dkat_pkg::ECOUNT_W'(fin_count);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("record count above table size");

	a_count_append: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> m_tvalid && m_tuser == dkat_pkg::STAT_APPEND)
		else $error("record count moved without an append result");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dkat_pkg::ST_SCAN && rd_vld_s1) |-> cmp_idx_s1 < count_q)
		else $error("scan compared an entry beyond the record count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == dkat_pkg::STAT_FULL) |-> count_q == CW'(MAX_ENTRIES))
		else $error("full reported with room left");
`endif

endmodule
